// File: rtl/uart_8n1_transceiver_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the UART core
// ---------------------------------------------------------------------------
`ifndef UART_8N1_TRANSCEIVER_CORE_MACROS_SVH
`define UART_8N1_TRANSCEIVER_CORE_MACROS_SVH

// Property checked on the rising clock edge, masked while reset is low.
`define UART8N1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define UART8N1_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/uart8n1_pkg.sv
// ---------------------------------------------------------------------------
// uart8n1_pkg
// Types and constants shared by the 8N1 UART core and its units.
// ---------------------------------------------------------------------------
package uart8n1_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned RxCountW = PeriodW + 1;
  localparam int unsigned FrameBits = 10;
  localparam int unsigned DataBits = 8;
  localparam int unsigned BitCountW = 4;

  localparam logic [PeriodW-1:0] BitPeriodReset = 16'd104;
  localparam logic [BitCountW-1:0] TxBitsInit = 4'd10;
  localparam logic [BitCountW-1:0] RxBitsInit = 4'd8;

  typedef struct packed {
    logic level;
    logic active;
  } tx_status_t;

  typedef struct packed {
    logic                valid;
    logic [DataBits-1:0] holding;
  } rx_status_t;

  // A zero bit period behaves as one tick.
  function automatic logic [PeriodW-1:0] period_now(input logic [PeriodW-1:0] bit_period);
    period_now = (bit_period == '0) ? PeriodW'(1) : bit_period;
  endfunction

endpackage

// File: rtl/uart_8n1_transceiver_core.sv
// ---------------------------------------------------------------------------
// uart_8n1_transceiver_core
// Full-duplex 8N1 UART driven by one timer tick per input word.
// ---------------------------------------------------------------------------
// Each input word is one timer tick carrying the sampled receive level and an
// optional byte to send; each tick yields exactly one output word with the
// transmit level, busy flag, receive strobe (tuser) and last received byte.
// One tick is taken per clock cycle while the output side keeps tready high:
// a tick is held in the input register, both UART sequencers update from it,
// and the result lands in the output register. The user must write
// bit_period through the cfg channel only while no tick is in flight; the
// block does not enforce this. A new value takes effect at the next bit
// boundary of each sequencer.
module uart_8n1_transceiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] rx_line, [8:1] send_byte
  input  logic        s_axis_tuser,   // [0] send_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] tx_line, [1] tx_busy, [9:2] rx_byte
  output logic        m_axis_tuser,   // [0] rx_valid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  `include "uart_8n1_transceiver_core_macros.svh"

  logic [uart8n1_pkg::PeriodW-1:0]  bit_period_q;
  logic                             in_valid_q;
  logic                             in_line_q;
  logic                             in_req_q;
  logic [uart8n1_pkg::DataBits-1:0] in_byte_q;
  logic                             out_valid_q;
  logic [15:0]                      out_data_q;
  logic                             out_user_q;
  logic                             advance;
  logic                             in_accept;
  uart8n1_pkg::tx_status_t          tx_status;
  uart8n1_pkg::rx_status_t          rx_status;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= uart8n1_pkg::BitPeriodReset;
    end else if (cfg_valid_i) begin
      bit_period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_line_q <= s_axis_tdata[0];
      in_byte_q <= s_axis_tdata[8:1];
      in_req_q  <= s_axis_tuser;
    end
  end

  uart8n1_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .req_i        (in_req_q),
    .byte_i       (in_byte_q),
    .bit_period_i (bit_period_q),
    .status_o     (tx_status)
  );

  uart8n1_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .line_i       (in_line_q),
    .bit_period_i (bit_period_q),
    .status_o     (rx_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, rx_status.holding, tx_status.active, tx_status.level};
      out_user_q <= rx_status.valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // a stalled tick stays put in the input register
  `UART8N1_ASSERT(a_in_hold, in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_line_q) && $stable(in_req_q), "input word lost while stalled")
  // every tick taken by the sequencers produces an output word
  `UART8N1_ASSERT(a_step_out, advance |=> out_valid_q, "tick did not produce an output word")
  // an edge seen in reset leaves the pipeline empty
  `UART8N1_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_q && !in_valid_q, "pipeline not empty in reset")

endmodule

// File: rtl/uart8n1_tx.sv
// ---------------------------------------------------------------------------
// uart8n1_tx
// Transmit sequencer: one update per accepted tick; status_o is the state
// after that tick.
// ---------------------------------------------------------------------------
module uart8n1_tx (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                req_i,
  input  logic [uart8n1_pkg::DataBits-1:0]    byte_i,
  input  logic [uart8n1_pkg::PeriodW-1:0]     bit_period_i,
  output uart8n1_pkg::tx_status_t             status_o
);

  logic [uart8n1_pkg::FrameBits-1:0] shift_q, shift_d;
  logic [uart8n1_pkg::BitCountW-1:0] bits_q, bits_d;
  logic [uart8n1_pkg::PeriodW-1:0]   count_q, count_d;
  logic                              active_q, active_d;
  logic                              level_q, level_d;

  always_comb begin
    shift_d  = shift_q;
    bits_d   = bits_q;
    count_d  = count_q;
    active_d = active_q;
    level_d  = level_q;
    if (active_q) begin
      if (count_q <= uart8n1_pkg::PeriodW'(1)) begin
        count_d = uart8n1_pkg::period_now(bit_period_i);
        if (bits_q == '0) begin
          active_d = 1'b0;
          bits_d   = uart8n1_pkg::TxBitsInit;
        end else begin
          level_d = shift_q[0];
          shift_d = {1'b0, shift_q[uart8n1_pkg::FrameBits-1:1]};
          bits_d  = bits_q - uart8n1_pkg::BitCountW'(1);
        end
      end else begin
        count_d = count_q - uart8n1_pkg::PeriodW'(1);
      end
    end else if (req_i) begin
      // stop, data, start from the top down
      shift_d  = {1'b1, byte_i, 1'b0};
      active_d = 1'b1;
      count_d  = uart8n1_pkg::period_now(bit_period_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      bits_q   <= uart8n1_pkg::TxBitsInit;
      count_q  <= '0;
      active_q <= 1'b0;
      level_q  <= 1'b1;
    end else if (step_i) begin
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      count_q  <= count_d;
      active_q <= active_d;
      level_q  <= level_d;
    end
  end

  assign status_o.level  = level_d;
  assign status_o.active = active_d;

endmodule

// File: rtl/uart8n1_rx.sv
// ---------------------------------------------------------------------------
// uart8n1_rx
// Receive sampler: edge detect, 1.5 period delay, eight samples LSB first.
// ---------------------------------------------------------------------------
module uart8n1_rx (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                line_i,
  input  logic [uart8n1_pkg::PeriodW-1:0]     bit_period_i,
  output uart8n1_pkg::rx_status_t             status_o
);

  logic                               sampling_q, sampling_d;
  logic [uart8n1_pkg::RxCountW-1:0]   count_q, count_d;
  logic [uart8n1_pkg::DataBits-1:0]   shift_q, shift_d;
  logic [uart8n1_pkg::BitCountW-1:0]  bits_q, bits_d;
  logic [uart8n1_pkg::DataBits-1:0]   holding_q, holding_d;
  logic                               prev_q;
  logic                               valid;
  logic [uart8n1_pkg::PeriodW-1:0]    period;

  assign period = uart8n1_pkg::period_now(bit_period_i);

  always_comb begin
    sampling_d = sampling_q;
    count_d    = count_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    holding_d  = holding_q;
    valid      = 1'b0;
    if (sampling_q) begin
      if (count_q <= uart8n1_pkg::RxCountW'(1)) begin
        count_d = uart8n1_pkg::RxCountW'(period);
        shift_d = {line_i, shift_q[uart8n1_pkg::DataBits-1:1]};
        bits_d  = bits_q - uart8n1_pkg::BitCountW'(1);
        if (bits_d == '0) begin
          holding_d  = shift_d;
          bits_d     = uart8n1_pkg::RxBitsInit;
          sampling_d = 1'b0;
          valid      = 1'b1;
        end
      end else begin
        count_d = count_q - uart8n1_pkg::RxCountW'(1);
      end
    end else if (prev_q && !line_i) begin
      // first sample lands mid bit: one and a half periods after the edge
      sampling_d = 1'b1;
      count_d    = uart8n1_pkg::RxCountW'(period)
                 + uart8n1_pkg::RxCountW'(bit_period_i[uart8n1_pkg::PeriodW-1:1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sampling_q <= 1'b0;
      count_q    <= '0;
      shift_q    <= '0;
      bits_q     <= uart8n1_pkg::RxBitsInit;
      holding_q  <= '0;
      prev_q     <= 1'b1;
    end else if (step_i) begin
      sampling_q <= sampling_d;
      count_q    <= count_d;
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      holding_q  <= holding_d;
      prev_q     <= line_i;
    end
  end

  assign status_o.valid   = valid;
  assign status_o.holding = holding_d;

endmodule
